>>> design/jes_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jes_pkg
// Shared types and constants for the JSON element splitter.
// ----------------------------------------------------------------------------
package jes_pkg;

   localparam int DepthBits = 8;

   localparam logic [7:0] CHAR_BACKSLASH   = 8'h5C;
   localparam logic [7:0] CHAR_QUOTE       = 8'h22;
   localparam logic [7:0] CHAR_BRACE_OPEN  = 8'h7B;
   localparam logic [7:0] CHAR_BRACE_CLOSE = 8'h7D;
   localparam logic [7:0] CHAR_BRACK_OPEN  = 8'h5B;
   localparam logic [7:0] CHAR_BRACK_CLOSE = 8'h5D;

   typedef enum logic [1:0] {
      KIND_STRING = 2'd0,
      KIND_OBJECT = 2'd1,
      KIND_ARRAY  = 2'd2
   } kind_type;

   typedef struct packed {
      logic in_element;
      logic first;
      logic last;
   } flags_type;

endpackage
`default_nettype wire

>>> design/jes_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jes_tracker
// String, escape and nesting state; frames the byte at the head of the pipe.
// ----------------------------------------------------------------------------
module jes_tracker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [7:0]         char_byte,
   output jes_pkg::flags_type      flags
);

   logic                           inside_string_ff, inside_string_in;
   logic                           escape_pending_ff, escape_pending_in;
   logic [jes_pkg::DepthBits-1:0]  object_depth_ff, object_depth_in;
   logic [jes_pkg::DepthBits-1:0]  array_depth_ff, array_depth_in;
   logic                           element_open_ff, element_open_in;
   jes_pkg::kind_type              element_kind_ff, element_kind_in;
   logic                           first;
   logic                           last;

   always_comb begin
      inside_string_in  = inside_string_ff;
      escape_pending_in = escape_pending_ff;
      object_depth_in   = object_depth_ff;
      array_depth_in    = array_depth_ff;
      element_open_in   = element_open_ff;
      element_kind_in   = element_kind_ff;
      first             = 1'b0;
      last              = 1'b0;
      if (escape_pending_ff) begin
         escape_pending_in = 1'b0;
      end else if (char_byte == jes_pkg::CHAR_BACKSLASH) begin
         escape_pending_in = 1'b1;
      end else if (char_byte == jes_pkg::CHAR_QUOTE) begin
         if (array_depth_ff < jes_pkg::DepthBits'(2)) begin
            if (!element_open_ff) begin
               element_open_in = 1'b1;
               element_kind_in = jes_pkg::KIND_STRING;
               first           = 1'b1;
            end else if (object_depth_ff == '0) begin
               element_open_in = 1'b0;
               last            = 1'b1;
            end
         end
         inside_string_in = !inside_string_ff;
      end else if (inside_string_ff) begin
         inside_string_in = inside_string_ff;
      end else if (char_byte == jes_pkg::CHAR_BRACE_CLOSE) begin
         object_depth_in = object_depth_ff - jes_pkg::DepthBits'(1);
         if (object_depth_in == '0 && element_open_ff &&
             element_kind_ff == jes_pkg::KIND_OBJECT) begin
            element_open_in = 1'b0;
            last            = 1'b1;
         end
      end else if (char_byte == jes_pkg::CHAR_BRACE_OPEN) begin
         object_depth_in = object_depth_ff + jes_pkg::DepthBits'(1);
         if (!element_open_ff) begin
            element_open_in = 1'b1;
            element_kind_in = jes_pkg::KIND_OBJECT;
            first           = 1'b1;
         end
      end else if (char_byte == jes_pkg::CHAR_BRACK_OPEN) begin
         array_depth_in = array_depth_ff + jes_pkg::DepthBits'(1);
         if (array_depth_in > jes_pkg::DepthBits'(1) && !element_open_ff) begin
            element_open_in = 1'b1;
            element_kind_in = jes_pkg::KIND_ARRAY;
            first           = 1'b1;
         end
      end else if (char_byte == jes_pkg::CHAR_BRACK_CLOSE) begin
         array_depth_in = array_depth_ff - jes_pkg::DepthBits'(1);
         if (array_depth_in == jes_pkg::DepthBits'(1) && element_open_ff &&
             element_kind_ff == jes_pkg::KIND_ARRAY) begin
            element_open_in = 1'b0;
            last            = 1'b1;
         end
      end
   end

   assign flags.in_element = element_open_ff || element_open_in;
   assign flags.first      = first;
   assign flags.last       = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_string_ff  <= 1'b0;
         escape_pending_ff <= 1'b0;
         object_depth_ff   <= '0;
         array_depth_ff    <= '0;
         element_open_ff   <= 1'b0;
         element_kind_ff   <= jes_pkg::KIND_STRING;
      end else if (step) begin
         inside_string_ff  <= inside_string_in;
         escape_pending_ff <= escape_pending_in;
         object_depth_ff   <= object_depth_in;
         array_depth_ff    <= array_depth_in;
         element_open_ff   <= element_open_in;
         element_kind_ff   <= element_kind_in;
      end
   end

endmodule
`default_nettype wire

>>> design/json_element_splitter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// json_element_splitter
// Echoes a JSON byte stream and frames every string, object or array element.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while rsp_tready is high and passes it through an
// input register and a result register; the framing state (string, escape and
// nesting depths) updates once per byte as it moves between the two. Only
// rsp_tready stalls the pipe: while it is high a byte moves every cycle; while
// it is low a full result register holds; req_tready drops once both are full.
// A transfer on the result side carries the byte, the in-element flag, the
// first-byte flag and tlast on the closing byte of an element. Depth counters
// wrap; malformed text is framed by the same rules without error.
// ----------------------------------------------------------------------------
module json_element_splitter (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_byte
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic [1:0]      rsp_tuser,   // [0] in_element, [1] element_first
   output logic            rsp_tlast    // element_last
);

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_byte_ff;
   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_byte_ff;
   jes_pkg::flags_type out_flags_ff;
   jes_pkg::flags_type flags;
   logic               advance;

   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   jes_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .char_byte (in_byte_ff),
      .flags     (flags)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (advance) begin
         out_byte_ff  <= in_byte_ff;
         out_flags_ff <= flags;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = {out_flags_ff.first, out_flags_ff.in_element};
   assign rsp_tlast  = out_flags_ff.last;

   a_first_in_element: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("first byte outside element");

   a_last_in_element: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[0])
      else $error("last byte outside element");

   a_first_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[1] && rsp_tlast))
      else $error("byte both opens and closes an element");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the JSON element splitter.
// ----------------------------------------------------------------------------
// A short directed stream opens the run: the byte extremes, escapes, string,
// object and array elements, and depth counters wrapping both ways. Most of
// the random part is well-formed JSON with random strings, escapes, scalars
// and nesting. Between documents come short bursts of unbalanced brackets,
// each followed by the bytes that bring the framing state back to rest. The
// run ends with a quote that closes an object element and with raw noise. A
// scoreboard frames every accepted byte and compares the echoed byte and its
// three flags with each result transfer. The sender works in bursts and the
// receiver stalls on patterns of its own, with one long hold-off; the sender
// waits for a full drain after the directed stream and at the halfway mark.
// ----------------------------------------------------------------------------
module tb_top;
   import jes_pkg::*;

   localparam int    CYCLE_LIMIT  = 400000;
   localparam int    RANDOM_BYTES = 1500;
   localparam string SCALAR_CHARS = "-+.eE0123456789truefalsn";

   typedef struct packed {
      logic [7:0] ch;
      flags_type  flags;
   } framed_byte_type;

   class element_frame_scoreboard;
      logic                 in_string;
      logic                 escape_armed;
      logic [DepthBits-1:0] obj_depth;
      logic [DepthBits-1:0] arr_depth;
      logic                 elem_open;
      kind_type             open_kind;
      framed_byte_type      expected_q[$];
      int                   mismatches;

      function new();
         in_string    = 1'b0;
         escape_armed = 1'b0;
         obj_depth    = '0;
         arr_depth    = '0;
         elem_open    = 1'b0;
         open_kind    = KIND_STRING;
         mismatches   = 0;
      endfunction

      function flags_type frame_byte(logic [7:0] c);
         flags_type f;
         logic      was_open;
         f        = '0;
         was_open = elem_open;
         if (escape_armed) begin
            escape_armed = 1'b0;
         end else if (c == CHAR_BACKSLASH) begin
            escape_armed = 1'b1;
         end else if (c == CHAR_QUOTE) begin
            if (arr_depth < 2) begin
               if (!elem_open) begin
                  elem_open = 1'b1;
                  open_kind = KIND_STRING;
                  f.first   = 1'b1;
               end else if (obj_depth == 0) begin
                  elem_open = 1'b0;
                  f.last    = 1'b1;
               end
            end
            in_string = !in_string;
         end else if (!in_string) begin
            case (c)
               CHAR_BRACE_CLOSE: begin
                  obj_depth = obj_depth - 1'b1;
                  if (obj_depth == 0 && elem_open && open_kind == KIND_OBJECT) begin
                     elem_open = 1'b0;
                     f.last    = 1'b1;
                  end
               end
               CHAR_BRACE_OPEN: begin
                  obj_depth = obj_depth + 1'b1;
                  if (!elem_open) begin
                     elem_open = 1'b1;
                     open_kind = KIND_OBJECT;
                     f.first   = 1'b1;
                  end
               end
               CHAR_BRACK_OPEN: begin
                  arr_depth = arr_depth + 1'b1;
                  if (arr_depth > 1 && !elem_open) begin
                     elem_open = 1'b1;
                     open_kind = KIND_ARRAY;
                     f.first   = 1'b1;
                  end
               end
               CHAR_BRACK_CLOSE: begin
                  arr_depth = arr_depth - 1'b1;
                  if (arr_depth == 1 && elem_open && open_kind == KIND_ARRAY) begin
                     elem_open = 1'b0;
                     f.last    = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         f.in_element = was_open | elem_open;
         return f;
      endfunction

      function void note_transfer(logic [7:0] c);
         framed_byte_type e;
         e.ch       = c;
         e.flags    = frame_byte(c);
         expected_q = {expected_q, e};
      endfunction

      function void check_result(logic [7:0] data, logic [1:0] user, logic tlast);
         framed_byte_type e;
         if (expected_q.size() == 0) begin
            $error("unexpected result transfer: out_byte %h", data);
            mismatches++;
            return;
         end
         e = expected_q.pop_front();
         if (data !== e.ch) begin
            $error("out_byte: expected %h, actual %h", e.ch, data);
            mismatches++;
         end
         if (user[0] !== e.flags.in_element) begin
            $error("in_element: expected %b, actual %b", e.flags.in_element, user[0]);
            mismatches++;
         end
         if (user[1] !== e.flags.first) begin
            $error("element_first: expected %b, actual %b", e.flags.first, user[1]);
            mismatches++;
         end
         if (tlast !== e.flags.last) begin
            $error("element_last: expected %b, actual %b", e.flags.last, tlast);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;

   element_frame_scoreboard ledger = new();
   element_frame_scoreboard plan   = new();
   int                      bytes_sent    = 0;
   int                      burst_left    = 0;
   int                      results_seen  = 0;

   json_element_splitter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   task automatic send_byte(input logic [7:0] c);
      int g;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 8);
         g = $urandom_range(0, 6);
         if (g != 0) begin
            req_tvalid <= 1'b0;
            repeat (g) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ledger.note_transfer(c);
      bytes_sent++;
   endtask

   task automatic put_byte(input logic [7:0] c);
      void'(plan.frame_byte(c));
      send_byte(c);
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (ledger.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] noise_byte(bit with_quotes);
      case ($urandom_range(0, with_quotes ? 7 : 5))
         0:       return CHAR_BRACE_OPEN;
         1:       return CHAR_BRACE_CLOSE;
         2:       return CHAR_BRACK_OPEN;
         3:       return CHAR_BRACK_CLOSE;
         4:       return " ";
         5:       return 8'($urandom_range(8'h61, 8'h7A));
         6:       return ($urandom_range(0, 1) == 0) ? CHAR_QUOTE : CHAR_BACKSLASH;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic put_ws();
      case ($urandom_range(0, 7))
         0:       put_byte(" ");
         1:       put_byte(8'h0A);
         2:       put_byte(8'h09);
         3:       put_byte(8'h0D);
         default: ;
      endcase
   endtask

   task automatic put_string();
      int         n;
      int         pick;
      logic [7:0] c;
      put_byte(CHAR_QUOTE);
      n = $urandom_range(0, 6);
      repeat (n) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1:    c = 8'($urandom_range(0, 255));
            2:       c = noise_byte(1'b1);
            default: c = 8'($urandom_range(8'h20, 8'h7E));
         endcase
         if (pick == 0 || c == CHAR_QUOTE || c == CHAR_BACKSLASH)
            put_byte(CHAR_BACKSLASH);
         put_byte(c);
      end
      put_byte(CHAR_QUOTE);
   endtask

   task automatic put_scalar();
      int n;
      n = $urandom_range(1, 5);
      repeat (n) put_byte(SCALAR_CHARS[$urandom_range(0, SCALAR_CHARS.len() - 1)]);
   endtask

   // one well-formed value, nested up to five levels
   task automatic gen_document();
      bit is_obj[$];
      int left[$];
      bit fresh[$];
      bit want_value;
      int pick;
      int top;
      want_value = 1'b1;
      while (want_value || is_obj.size() != 0) begin
         if (want_value) begin
            want_value = 1'b0;
            pick = $urandom_range(0, 9);
            if (is_obj.size() < 5 && pick < 5) begin
               put_byte(pick < 2 ? CHAR_BRACE_OPEN : CHAR_BRACK_OPEN);
               is_obj = {is_obj, (pick < 2)};
               left   = {left, int'($urandom_range(0, 4))};
               fresh  = {fresh, 1'b1};
            end else if (pick < 8) begin
               put_string();
            end else begin
               put_scalar();
            end
         end else begin
            top = is_obj.size() - 1;
            if (left[top] == 0) begin
               put_byte(is_obj[top] ? CHAR_BRACE_CLOSE : CHAR_BRACK_CLOSE);
               void'(is_obj.pop_back());
               void'(left.pop_back());
               void'(fresh.pop_back());
            end else begin
               if (!fresh[top]) put_byte(",");
               fresh[top] = 1'b0;
               left[top]  = left[top] - 1;
               if (is_obj[top]) begin
                  put_string();
                  put_byte(":");
               end
               want_value = 1'b1;
            end
         end
         if ($urandom_range(0, 2) == 0) put_ws();
      end
   endtask

   // bring depths back to zero and close any open element, outside a string
   task automatic restore_framing();
      while (plan.escape_armed || plan.obj_depth != 0 || plan.arr_depth != 0 ||
             plan.elem_open) begin
         if (plan.escape_armed) begin
            put_byte(" ");
         end else if (plan.obj_depth != 0) begin
            put_byte(plan.obj_depth[DepthBits-1] ? CHAR_BRACE_OPEN : CHAR_BRACE_CLOSE);
         end else if (plan.arr_depth != 0) begin
            put_byte(plan.arr_depth[DepthBits-1] ? CHAR_BRACK_OPEN : CHAR_BRACK_CLOSE);
         end else if (plan.open_kind == KIND_OBJECT) begin
            put_byte(CHAR_BRACE_OPEN);
         end else begin
            put_byte(CHAR_BRACK_OPEN);
            put_byte(CHAR_BRACK_OPEN);
            put_byte(CHAR_BRACK_CLOSE);
            put_byte(CHAR_BRACK_CLOSE);
         end
      end
   endtask

   initial begin : result_sink
      int mode;
      int mode_left;
      int hold_left;
      mode      = 0;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            ledger.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
            results_seen++;
            if (results_seen == 400) hold_left = 250;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(16, 96);
         end
         mode_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      string head;
      int    k;
      int    n;
      bit    mid_drained;
      head        = "\"x\\\"\"[[\"\"]]{\"\"}}{{}][\\{";
      mid_drained = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      put_byte(8'h00);
      put_byte(8'hFF);
      for (k = 0; k < head.len(); k++) put_byte(head[k]);
      restore_framing();
      wait_for_drain();

      while (bytes_sent < RANDOM_BYTES) begin
         if ($urandom_range(0, 6) == 0) begin
            n = $urandom_range(1, 10);
            repeat (n) put_byte(noise_byte(1'b0));
            restore_framing();
         end else begin
            gen_document();
         end
         put_ws();
         if (!mid_drained && bytes_sent >= RANDOM_BYTES / 2) begin
            mid_drained = 1'b1;
            wait_for_drain();
         end
      end

      // a quote closes an object element opened at wrapped depth zero
      put_byte(CHAR_BRACE_CLOSE);
      put_byte(CHAR_BRACE_OPEN);
      put_byte(CHAR_QUOTE);
      repeat (200) put_byte(noise_byte(1'b1));

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (ledger.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> filelist.f
design/jes_pkg.sv
design/jes_tracker.sv
design/json_element_splitter.sv
dv/tb_top.sv
